// File: rtl/skeleton_joint_end_detect_core_assert.svh
// ----------------------------------------------------------------------------
// Skeleton joint/end detector assertion macros
// Concurrent assertion helpers used by the detector core RTL file.
// ----------------------------------------------------------------------------
`ifndef SKELETON_JOINT_END_DETECT_CORE_ASSERT_SVH
`define SKELETON_JOINT_END_DETECT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define SJED_ASSERT(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (prop)) \
		else $error("sjed assertion failed");
// Condition must never be true at a rising clock edge outside reset.
`define SJED_NEVER(label, clock, rst_n, cond) \
	label: assert property (@(posedge clock) disable iff (!rst_n) !(cond)) \
		else $error("sjed forbidden condition seen");
`else
`define SJED_ASSERT(label, clock, rst_n, prop)
`define SJED_NEVER(label, clock, rst_n, cond)
`endif

`endif

// File: rtl/sjed_pkg.sv
// ----------------------------------------------------------------------------
// Skeleton joint/end detector package
// Shared constants, types and the ring classification function.
// ----------------------------------------------------------------------------
`default_nettype none

package sjed_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int PIX_W   = 8;
	localparam int CFG_W   = 11;
	localparam int COORD_W = 10;

	localparam int MIN_WIDTH = 3;
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 11'd640;
	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

	// Result queue between the window stage and the output channel.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	// Window cells around the center in circular order; neighbors are 4-adjacent.
	localparam int unsigned RING_ORDER [8] = '{0, 1, 2, 5, 8, 7, 6, 3};

	typedef enum logic {
		KIND_END   = 1'b0,
		KIND_JOINT = 1'b1
	} point_kind_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		point_kind_t        kind;
	} point_t;

	typedef struct packed {
		logic [FIFO_CW-1:0] count;
	} fifo_status_t;

	// Number of zero regions around the ring: circular runs of zero flags,
	// with an all-zero ring counting as one region.
	function automatic logic [3:0] zero_regions(input logic [7:0] z);
		logic [3:0] runs;
		runs = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (z[i] && !z[(i + 7) & 7]) begin
				runs = runs + 4'd1;
			end
		end
		if (z == 8'hFF) begin
			runs = 4'd1;
		end
		return runs;
	endfunction

endpackage

`default_nettype wire

// File: rtl/sjed_ifs.sv
// ----------------------------------------------------------------------------
// Skeleton joint/end detector channel interfaces
// Valid/ready channels for pixels, detected points and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface sjed_pixel_if
	import sjed_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             start_of_frame;

	modport source (output valid, output pixel, output start_of_frame, input ready);
	modport sink (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface sjed_point_if
	import sjed_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] point_x;
	logic [COORD_W-1:0] point_y;
	logic               point_kind;

	modport source (output valid, output point_x, output point_y, output point_kind,
		input ready);
	modport sink (input valid, input point_x, input point_y, input point_kind,
		output ready);
endinterface

interface sjed_cfg_if
	import sjed_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] frame_width;

	modport source (output valid, output frame_width, input ready);
	modport sink (input valid, input frame_width, output ready);
endinterface

`default_nettype wire

// File: rtl/sjed_line_mem.sv
// ----------------------------------------------------------------------------
// Line store memory
// Synchronous memory holding both buffered rows per column, one read and
// one write per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sjed_line_mem
	import sjed_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_WIDTH,
	parameter int AW    = $clog2(DEF_MAX_WIDTH),
	parameter int DW    = 2 * PIX_W
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/sjed_window.sv
// ----------------------------------------------------------------------------
// 3x3 window and classifier
// Shifts the new column into the window and classifies the center pixel
// as an end point or a joint from the zero regions around it.
// ----------------------------------------------------------------------------
`default_nettype none

module sjed_window
	import sjed_pkg::*;
#(
	parameter int CW = $clog2(DEF_MAX_WIDTH),
	parameter int RW = $clog2(DEF_MAX_HEIGHT)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [PIX_W-1:0] up,
	input  wire logic [PIX_W-1:0] mid,
	input  wire logic [PIX_W-1:0] pix,
	input  wire logic [CW-1:0]    x,
	input  wire logic [RW-1:0]    y,
	output logic                  res_valid,
	output point_t                res
);

	logic [PIX_W-1:0] win_q [9];
	logic [PIX_W-1:0] win_d [9];
	logic [7:0]       ring_zero;
	logic [3:0]       regions;

	always_comb begin
		win_d[0] = win_q[1];
		win_d[1] = win_q[2];
		win_d[2] = up;
		win_d[3] = win_q[4];
		win_d[4] = win_q[5];
		win_d[5] = mid;
		win_d[6] = win_q[7];
		win_d[7] = win_q[8];
		win_d[8] = pix;
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			ring_zero[i] = (win_d[RING_ORDER[i]] == '0);
		end
	end

	assign regions = zero_regions(ring_zero);

	always_comb begin
		res_valid = in_valid && (x >= CW'(2)) && (y >= RW'(2)) && (win_d[4] == PIX_WHITE)
			&& ((regions == 4'd1) || (regions >= 4'd3));
		res.x     = COORD_W'(x - CW'(1));
		res.y     = COORD_W'(y - RW'(1));
		res.kind  = (regions >= 4'd3) ? KIND_JOINT : KIND_END;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (in_valid) begin
			win_q <= win_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sjed_point_fifo.sv
// ----------------------------------------------------------------------------
// Detected point queue
// Small register queue that decouples the window stage from the output
// channel and reports its fill level for input flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module sjed_point_fifo
	import sjed_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire point_t   din,
	sjed_point_if.source  points,
	output fifo_status_t  status
);

	point_t               entries_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;

	assign pop = points.valid && points.ready;

	assign points.valid      = (count_q != '0);
	assign points.point_x    = entries_q[rd_ptr_q].x;
	assign points.point_y    = entries_q[rd_ptr_q].y;
	assign points.point_kind = entries_q[rd_ptr_q].kind;
	assign status.count      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

endmodule

`default_nettype wire

// File: rtl/skeleton_joint_end_detect_core.sv
// Output path: the pixel that completes a window (one row and one column after the
// center) is registered in stage one, and a detected point is then registered in the
// point queue before points.valid rises for it.
// Throughput: one pixel per clock, set by the single read and write per pixel on the
// line store memory; input stalls while queued points plus stage one reach four.
// Reset: counters and window clear, frame width returns to 640; the line store
// memory is not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
// Skeleton joint/end detector core
// Streams a skeleton image through a two-row line store and a 3x3 window and
// reports end points and joints with their coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

`include "skeleton_joint_end_detect_core_assert.svh"

module skeleton_joint_end_detect_core
	import sjed_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sjed_cfg_if.sink     cfg,
	sjed_pixel_if.sink   pixels,
	sjed_point_if.source points
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int EW = CW + 1;
	localparam int DW = 2 * PIX_W;

	logic [CFG_W-1:0] fw_q;
	logic [EW-1:0]    eff_width;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;

	logic             accept;
	logic [CW-1:0]    x0;
	logic [RW-1:0]    y0;
	logic [EW-1:0]    x_inc;
	logic             wrap;

	logic             v_s1;
	logic             fwd_s1;
	logic [CW-1:0]    x_s1;
	logic [RW-1:0]    y_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [DW-1:0]    wprev_q;

	logic [DW-1:0]    mem_rdata;
	logic [DW-1:0]    rd_eff;
	logic [DW-1:0]    wdata;

	logic             res_valid;
	point_t           res;
	fifo_status_t     fifo_st;
	logic             pop;

	// Configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_WIDTH_RESET;
		end else if (cfg.valid) begin
			fw_q <= cfg.frame_width;
		end
	end

	always_comb begin
		if (fw_q < CFG_W'(MIN_WIDTH)) begin
			eff_width = EW'(MIN_WIDTH);
		end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			eff_width = EW'(MAX_WIDTH);
		end else begin
			eff_width = EW'(fw_q);
		end
	end

	// Input stage: position of the incoming pixel and line store read.
	// Up to four results can be in flight, counting the queue and stage one.
	assign pixels.ready = (fifo_st.count + FIFO_CW'(v_s1)) < FIFO_CW'(FIFO_DEPTH);
	assign accept       = pixels.valid && pixels.ready;

	assign x0    = pixels.start_of_frame ? '0 : col_q;
	assign y0    = pixels.start_of_frame ? '0 : row_q;
	assign x_inc = {1'b0, x0} + EW'(1);
	assign wrap  = (x_inc >= eff_width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= (y0 < RW'(MAX_HEIGHT - 1)) ? y0 + RW'(1) : y0;
			end else begin
				col_q <= x_inc[CW-1:0];
				row_q <= y0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= accept;
			// Stage one writes the column being read now; take its data instead.
			fwd_s1 <= accept && v_s1 && (x0 == x_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= x0;
			y_s1   <= y0;
			pix_s1 <= pixels.pixel;
		end
		if (v_s1) begin
			wprev_q <= wdata;
		end
	end

	// Stage one: read data, write back, window update
	assign rd_eff = fwd_s1 ? wprev_q : mem_rdata;
	assign wdata  = {rd_eff[PIX_W-1:0], pix_s1};

	sjed_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW),
		.DW    (DW)
	) u_line_mem (
		.clk   (clk),
		.we    (v_s1),
		.waddr (x_s1),
		.wdata (wdata),
		.raddr (x0),
		.rdata (mem_rdata)
	);

	sjed_window #(
		.CW (CW),
		.RW (RW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.up        (rd_eff[DW-1:PIX_W]),
		.mid       (rd_eff[PIX_W-1:0]),
		.pix       (pix_s1),
		.x         (x_s1),
		.y         (y_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	sjed_point_fifo u_point_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    (res),
		.points (points),
		.status (fifo_st)
	);

	assign pop = points.valid && points.ready;

	`SJED_NEVER(a_fifo_overflow, clk, arst_n, res_valid && (fifo_st.count == FIFO_CW'(FIFO_DEPTH)) && !pop)
	`SJED_ASSERT(a_credit_bound, clk, arst_n, (fifo_st.count + FIFO_CW'(v_s1)) <= FIFO_CW'(FIFO_DEPTH))
	`SJED_ASSERT(a_sof_origin, clk, arst_n, accept && pixels.start_of_frame |=> (x_s1 == '0) && (y_s1 == '0))
	`SJED_ASSERT(a_inner_center, clk, arst_n, res_valid |-> (x_s1 >= CW'(2)) && (y_s1 >= RW'(2)))

endmodule

`default_nettype wire
